>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/hwr_pkg.sv
// ----------------------------------------------------------------------------
// hwr_pkg
// types and constants of the hermite waypoint replay block
// ----------------------------------------------------------------------------
package hwr_pkg;
	localparam int MAX_WAYPOINTS_DEF = 256;
	localparam int DIV_DW = 26;
	localparam int DIV_VW = 10;
	localparam int MS_PER_S = 1000;

	localparam logic [2:0] KIND_CLEAR  = 3'd0;
	localparam logic [2:0] KIND_APPEND = 3'd1;
	localparam logic [2:0] KIND_START  = 3'd2;
	localparam logic [2:0] KIND_TICK   = 3'd3;
	localparam logic [2:0] KIND_STOP   = 3'd4;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_FEW  = 2'd2;
	localparam logic [1:0] ERR_BUSY = 2'd3;

	localparam logic CFG_TICKS  = 1'b0;
	localparam logic CFG_PERIOD = 1'b1;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] way_pos_shoulder;
		logic signed [15:0] way_pos_elbow;
		logic signed [15:0] way_vel_shoulder;
		logic signed [15:0] way_vel_elbow;
	} req_t;

	typedef struct packed {
		logic signed [15:0] cmd_pos_shoulder;
		logic signed [15:0] cmd_pos_elbow;
		logic               cmd_valid;
		logic               moving;
		logic               done_res;
		logic [1:0]         error_code;
	} rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_DW-1:0] quo;
		logic [DIV_VW-1:0] rem;
	} div_rsp_t;
endpackage

>>> rtl/core/hwr_div.sv
// ----------------------------------------------------------------------------
// hwr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hwr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  hwr_pkg::div_req_t req,
	output hwr_pkg::div_rsp_t rsp
);
	import hwr_pkg::*;

	localparam int CNTW = $clog2(DIV_DW + 1);

	logic [DIV_DW-1:0] work_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [CNTW-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_VW:0]   trial;
	logic [DIV_VW:0]   diff;
	logic              take;

	assign trial = {rem_q, work_q[DIV_DW-1]};
	assign take  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DIV_DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_DW-2:0], take};
			rem_q  <= take ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = work_q;
	assign rsp.rem  = rem_q;
endmodule

>>> rtl/core/hermite_waypoint_replay_top.sv
// ----------------------------------------------------------------------------
// hermite_waypoint_replay_top
// two-axis cubic hermite waypoint table and replay interpolator
// ----------------------------------------------------------------------------
// usage:
//   req channel (valid/ready) carries one item: clear, append, start, tick
//   or stop. rsp channel (valid/ready) returns exactly one item for each.
//   cfg_we/cfg_addr/cfg_wdata write ticks_per_segment (0) and
//   tick_period_ms (1); write only while the block is idle.
//   clear, append, start, stop and idle ticks go straight to the result.
//   an interpolating tick runs the shared 26-step divider twice (segment
//   split, phase), then one shared 20x20 multiplier runs 18 product steps,
//   each through S_MUL and S_ACC, and each axis that does not saturate ends
//   its rounding in a constant reciprocal multiply. the tick that reaches the
//   final waypoint runs only the segment split and reads the last entry.
//   one item is in work at a time; req_ready is low while it runs.
//   a finished result waits in the output register while rsp_ready is low;
//   a further result then holds in S_FIN and the block takes no new item.
//   reset clears the table count, the replay state and both registers to
//   10 ticks and 100 ms; table entries are undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hermite_waypoint_replay_top #(
	parameter int MAX_WAYPOINTS = hwr_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hwr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hwr_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_addr,
	input  logic [9:0]    cfg_wdata
);
	import hwr_pkg::*;

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam logic signed [55:0] RND_HALF = 56'sd16384000;
	localparam logic signed [55:0] SAT_LIM  = 56'sd32768000;
	// ceil(2^36 / 1000), exact floor quotient for offsets below 2^26
	localparam logic [26:0] RECIP_MS = 27'd68719477;

	typedef enum logic [3:0] {
		S_IDLE, S_FIN, S_SEGDIV, S_SEL, S_LAST, S_RD1, S_SDIV,
		S_MUL, S_ACC, S_HERM, S_RND, S_QDIV
	} state_t;

	state_t state_q;
	logic [7:0]  tps_q;
	logic [9:0]  tpm_q;
	logic [CW-1:0] count_q;
	logic [17:0] tick_q;
	logic active_q;
	rsp_t res_q, rsp_q;
	logic rsp_valid_q;

	logic [63:0] mem [MAX_WAYPOINTS];
	logic [63:0] rdata_q, w0_q, w1_q;
	logic rd_en;
	logic [AW-1:0] rd_addr;

	logic [7:0]  n_q, u_q;
	logic [17:0] seg_q, scale_q;
	logic [15:0] s_q, s2_q, s3_q;
	logic signed [19:0] h00_q, h01_q, h10_q, h11_q;
	logic [3:0]  step_q;
	logic        axis_q;
	logic signed [39:0] prod_q;
	logic signed [33:0] y_q, z_q;
	logic signed [55:0] a_q;
	logic signed [15:0] cs_q;
	logic [25:0] roff_q;
	logic [51:0] quo_full;

	logic signed [19:0] ma, mb, p0, p1, v0, v1;
	logic signed [55:0] prod_ext, a_rnd, b_val, b_off;
	logic [7:0]  n_cur;
	logic [CW-1:0] last;
	logic        req_fire, fin_en;
	logic signed [15:0] fin_val;
	div_req_t div_req;
	div_rsp_t div_rsp;

	hwr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign n_cur     = (tps_q == 8'd0) ? 8'd1 : tps_q;
	assign last      = count_q - 1'b1;

	// operand select, word layout {vel_el, vel_sh, pos_el, pos_sh}
	assign p0 = 20'(signed'(axis_q ? w0_q[31:16] : w0_q[15:0]));
	assign p1 = 20'(signed'(axis_q ? w1_q[31:16] : w1_q[15:0]));
	assign v0 = 20'(signed'(axis_q ? w0_q[63:48] : w0_q[47:32]));
	assign v1 = 20'(signed'(axis_q ? w1_q[63:48] : w1_q[47:32]));

	always_comb begin
		unique case (step_q)
			4'd0: begin ma = 20'(s_q); mb = 20'(s_q); end
			4'd1: begin ma = 20'(s2_q); mb = 20'(s_q); end
			4'd2: begin ma = h00_q; mb = p0; end
			4'd3: begin ma = h01_q; mb = p1; end
			4'd4: begin ma = h10_q; mb = v0; end
			4'd5: begin ma = h11_q; mb = v1; end
			4'd6: begin ma = 20'(MS_PER_S); mb = {1'b0, y_q[18:0]}; end
			4'd7: begin ma = 20'(MS_PER_S); mb = 20'(signed'(y_q[33:19])); end
			4'd8: begin ma = {2'b00, scale_q}; mb = {1'b0, z_q[18:0]}; end
			4'd9: begin ma = {2'b00, scale_q}; mb = 20'(signed'(z_q[33:19])); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	assign prod_ext = {{16{prod_q[39]}}, prod_q};
	assign a_rnd    = a_q + RND_HALF;
	assign b_val    = a_rnd >>> 15;
	assign b_off    = b_val + SAT_LIM;
	assign quo_full = 52'(roff_q) * 52'(RECIP_MS);

	always_comb begin
		fin_en  = 1'b0;
		fin_val = '0;
		if (state_q == S_RND) begin
			if (b_val >= SAT_LIM) begin
				fin_en  = 1'b1;
				fin_val = 16'sh7fff;
			end else if (b_val < -SAT_LIM) begin
				fin_en  = 1'b1;
				fin_val = -16'sh8000;
			end
		end else if (state_q == S_QDIV) begin
			fin_en  = 1'b1;
			fin_val = quo_full[51:36] - 16'h8000;
		end
	end

	always_comb begin
		div_req = '0;
		if (req_fire && req.kind == KIND_TICK && active_q && count_q >= CW'(2)) begin
			div_req.start    = 1'b1;
			div_req.dividend = DIV_DW'(tick_q);
			div_req.divisor  = DIV_VW'(n_cur);
		end else if (state_q == S_SEL && seg_q < 18'(last)) begin
			div_req.start    = 1'b1;
			div_req.dividend = DIV_DW'({u_q, 15'd0});
			div_req.divisor  = DIV_VW'(n_q);
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == S_SEL) begin
			rd_en   = 1'b1;
			rd_addr = (seg_q >= 18'(last)) ? last[AW-1:0] : seg_q[AW-1:0];
		end else if (state_q == S_RD1) begin
			rd_en   = 1'b1;
			rd_addr = seg_q[AW-1:0] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && req.kind == KIND_APPEND && !active_q
				&& count_q < CW'(MAX_WAYPOINTS))
			mem[count_q[AW-1:0]] <= {req.way_vel_elbow, req.way_vel_shoulder,
				req.way_pos_elbow, req.way_pos_shoulder};
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tps_q       <= 8'd10;
			tpm_q       <= 10'd100;
			count_q     <= '0;
			tick_q      <= '0;
			active_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			res_q       <= '0;
			step_q      <= '0;
			axis_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_TICKS:  tps_q <= cfg_wdata[7:0];
					CFG_PERIOD: tpm_q <= cfg_wdata;
				endcase
			end
			if (rsp_valid_q && rsp_ready && state_q != S_FIN)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= (req.kind == KIND_TICK && active_q && count_q >= CW'(2))
							? S_SEGDIV : S_FIN;
						unique case (req.kind)
							KIND_CLEAR: begin
								if (active_q) begin
									res_q.error_code <= ERR_BUSY;
									res_q.moving     <= 1'b1;
								end else count_q <= '0;
							end
							KIND_APPEND: begin
								if (active_q) begin
									res_q.error_code <= ERR_BUSY;
									res_q.moving     <= 1'b1;
								end else if (count_q >= CW'(MAX_WAYPOINTS))
									res_q.error_code <= ERR_FULL;
								else count_q <= count_q + 1'b1;
							end
							KIND_START: begin
								if (active_q) begin
									res_q.error_code <= ERR_BUSY;
									res_q.moving     <= 1'b1;
								end else if (count_q < CW'(2)) begin
									res_q.error_code <= ERR_FEW;
								end else begin
									tick_q       <= '0;
									active_q     <= 1'b1;
									res_q.moving <= 1'b1;
								end
							end
							KIND_TICK: begin
								if (active_q && count_q >= CW'(2)) begin
									n_q     <= n_cur;
									scale_q <= 18'(n_cur) * 18'(tpm_q);
								end else begin
									active_q <= 1'b0;
								end
							end
							KIND_STOP: active_q <= 1'b0;
							default: res_q.moving <= active_q;
						endcase
					end
				end
				S_SEGDIV: begin
					if (div_rsp.done) begin
						seg_q   <= div_rsp.quo[17:0];
						u_q     <= div_rsp.rem[7:0];
						state_q <= S_SEL;
					end
				end
				S_SEL: state_q <= (seg_q >= 18'(last)) ? S_LAST : S_RD1;
				S_LAST: begin
					res_q.cmd_pos_shoulder <= rdata_q[15:0];
					res_q.cmd_pos_elbow    <= rdata_q[31:16];
					res_q.cmd_valid        <= 1'b1;
					res_q.done_res         <= 1'b1;
					res_q.moving           <= 1'b0;
					active_q               <= 1'b0;
					state_q                <= S_FIN;
				end
				S_RD1: begin
					w0_q    <= rdata_q;
					state_q <= S_SDIV;
				end
				S_SDIV: begin
					if (div_rsp.done) begin
						w1_q    <= rdata_q;
						s_q     <= div_rsp.quo[15:0];
						step_q  <= 4'd0;
						axis_q  <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'd1) state_q <= S_HERM;
					else if (step_q == 4'd9) state_q <= S_RND;
					else if (step_q > 4'd9) state_q <= S_IDLE;
					else state_q <= S_MUL;
					unique case (step_q)
						4'd0: s2_q <= prod_q[30:15];
						4'd1: s3_q <= prod_q[30:15];
						4'd2: y_q <= prod_q[33:0];
						4'd3: y_q <= y_q + prod_q[33:0];
						4'd4: z_q <= prod_q[33:0];
						4'd5: z_q <= z_q + prod_q[33:0];
						4'd6: a_q <= prod_ext;
						4'd7: a_q <= a_q + (prod_ext <<< 19);
						4'd8: a_q <= a_q + prod_ext;
						4'd9: a_q <= a_q + (prod_ext <<< 19);
						default: ;
					endcase
				end
				S_HERM: begin
					h01_q   <= 20'sd3 * 20'(s2_q) - 20'sd2 * 20'(s3_q);
					h00_q   <= 20'sd32768 - (20'sd3 * 20'(s2_q) - 20'sd2 * 20'(s3_q));
					h10_q   <= 20'(s3_q) - 20'sd2 * 20'(s2_q) + 20'(s_q);
					h11_q   <= 20'(s3_q) - 20'(s2_q);
					state_q <= S_MUL;
				end
				S_RND: begin
					if (!fin_en) begin
						roff_q  <= b_off[25:0];
						state_q <= S_QDIV;
					end
				end
				S_QDIV: ;
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						res_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (fin_en) begin
				if (!axis_q) begin
					cs_q    <= fin_val;
					axis_q  <= 1'b1;
					step_q  <= 4'd2;
					state_q <= S_MUL;
				end else begin
					res_q.cmd_pos_shoulder <= cs_q;
					res_q.cmd_pos_elbow    <= fin_val;
					res_q.cmd_valid        <= 1'b1;
					res_q.moving           <= 1'b1;
					tick_q                 <= tick_q + 1'b1;
					state_q                <= S_FIN;
				end
			end
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(MAX_WAYPOINTS))
	`ASSERT_PROP(a_active_count, clk, arst_n, active_q |-> count_q >= CW'(2))
	`ASSERT_NEVER(a_done_moving, clk, arst_n, rsp_valid_q && rsp_q.done_res && rsp_q.moving)
	`ASSERT_PROP(a_ready_idle, clk, arst_n, req_fire |=> !req_ready)
endmodule

>>> tb/tb_hermite_waypoint_replay_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hermite_waypoint_replay_top
// self-checking bench for the hermite waypoint replay block
// ----------------------------------------------------------------------------
// builds waypoint tables, replays them tick by tick under several segment
// lengths and tick periods, and mixes in busy, full, too-few and stray kinds.
// a local hermite predictor queues one expected rsp item per req item, and
// the monitor compares every rsp item field by field in order.
// ----------------------------------------------------------------------------
module tb_hermite_waypoint_replay_top;
	import hwr_pkg::*;

	localparam int NWAY = MAX_WAYPOINTS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_addr = 1'b0;
	logic [9:0] cfg_wdata = '0;

	hermite_waypoint_replay_top DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	logic signed [15:0] tab_psh [NWAY];
	logic signed [15:0] tab_pel [NWAY];
	logic signed [15:0] tab_vsh [NWAY];
	logic signed [15:0] tab_vel [NWAY];
	int unsigned way_cnt, tick_cnt;
	bit replaying;
	int unsigned seg_ticks, period_ms;

	req_t pending_items [$];
	rsp_t expected_rsp [$];
	int errors, sent, received, ticks_cmd, dones;

	function automatic logic signed [15:0] blend(longint h00, longint h01, longint h10,
			longint h11, longint p0, longint p1, longint v0, longint v1, longint scale);
		longint den, acc, q;
		den = 64'd1000 * 32768;
		acc = 1000 * (h00 * p0 + h01 * p1) + scale * (h10 * v0 + h11 * v1) + den / 2;
		if (acc >= 0) q = acc / den;
		else q = -((-acc + den - 1) / den);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic rsp_t predict_replay(req_t it);
		rsp_t r;
		int unsigned n, seg, u, last;
		longint s, s2, s3, h00, h01, h10, h11, sc;
		r = '0;
		case (it.kind)
			KIND_CLEAR: begin
				if (replaying) r.error_code = ERR_BUSY;
				else way_cnt = 0;
			end
			KIND_APPEND: begin
				if (replaying) r.error_code = ERR_BUSY;
				else if (way_cnt >= NWAY) r.error_code = ERR_FULL;
				else begin
					tab_psh[way_cnt] = it.way_pos_shoulder;
					tab_pel[way_cnt] = it.way_pos_elbow;
					tab_vsh[way_cnt] = it.way_vel_shoulder;
					tab_vel[way_cnt] = it.way_vel_elbow;
					way_cnt++;
				end
			end
			KIND_START: begin
				if (replaying) r.error_code = ERR_BUSY;
				else if (way_cnt < 2) r.error_code = ERR_FEW;
				else begin
					tick_cnt = 0;
					replaying = 1;
				end
			end
			KIND_TICK: begin
				if (replaying && way_cnt >= 2) begin
					n = (seg_ticks == 0) ? 1 : seg_ticks;
					seg = tick_cnt / n;
					u = tick_cnt % n;
					last = way_cnt - 1;
					r.cmd_valid = 1'b1;
					if (seg >= last) begin
						r.cmd_pos_shoulder = tab_psh[last];
						r.cmd_pos_elbow = tab_pel[last];
						r.done_res = 1'b1;
						replaying = 0;
					end else begin
						s = (longint'(u) << 15) / n;
						s2 = (s * s) >>> 15;
						s3 = (s2 * s) >>> 15;
						h01 = 3 * s2 - 2 * s3;
						h00 = 32768 - h01;
						h10 = s3 - 2 * s2 + s;
						h11 = s3 - s2;
						sc = longint'(n) * period_ms;
						r.cmd_pos_shoulder = blend(h00, h01, h10, h11, tab_psh[seg],
							tab_psh[seg + 1], tab_vsh[seg], tab_vsh[seg + 1], sc);
						r.cmd_pos_elbow = blend(h00, h01, h10, h11, tab_pel[seg],
							tab_pel[seg + 1], tab_vel[seg], tab_vel[seg + 1], sc);
						tick_cnt = (tick_cnt + 1) & 18'h3FFFF;
					end
				end else replaying = 0;
			end
			KIND_STOP: replaying = 0;
			default: ;
		endcase
		r.moving = replaying;
		return r;
	endfunction

	// driver: bursts with random gaps
	int gap_left = 0, burst_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_rsp = {expected_rsp, predict_replay(req)};
				sent++;
			end
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req <= pending_items.pop_front();
					req_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
					end else burst_left <= burst_left - 1;
				end else req_valid <= 1'b0;
			end
		end
	end

	// monitor with its own stall pattern
	int unsigned stall_phase = 0;
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			stall_phase <= stall_phase + 1;
			rsp_ready <= (stall_phase[6:5] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
			if (rsp_valid && rsp_ready) begin
				received++;
				if (expected_rsp.size() == 0) begin
					$error("rsp item with nothing expected");
					errors++;
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.cmd_valid) ticks_cmd++;
					if (rsp.done_res) dones++;
					if (rsp.cmd_pos_shoulder !== e.cmd_pos_shoulder) begin
						$error("cmd_pos_shoulder exp %0d got %0d", e.cmd_pos_shoulder,
							rsp.cmd_pos_shoulder);
						errors++;
					end
					if (rsp.cmd_pos_elbow !== e.cmd_pos_elbow) begin
						$error("cmd_pos_elbow exp %0d got %0d", e.cmd_pos_elbow, rsp.cmd_pos_elbow);
						errors++;
					end
					if (rsp.cmd_valid !== e.cmd_valid) begin
						$error("cmd_valid exp %0b got %0b", e.cmd_valid, rsp.cmd_valid);
						errors++;
					end
					if (rsp.moving !== e.moving) begin
						$error("moving exp %0b got %0b", e.moving, rsp.moving);
						errors++;
					end
					if (rsp.done_res !== e.done_res) begin
						$error("done_res exp %0b got %0b", e.done_res, rsp.done_res);
						errors++;
					end
					if (rsp.error_code !== e.error_code) begin
						$error("error_code exp %0d got %0d", e.error_code, rsp.error_code);
						errors++;
					end
				end
			end
		end
	end

	function automatic logic signed [15:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return $urandom_range(0, 400) - 200;
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_item(logic [2:0] k);
		req_t it;
		it.kind = k;
		it.way_pos_shoulder = rand_word();
		it.way_pos_elbow = rand_word();
		it.way_vel_shoulder = rand_word();
		it.way_vel_elbow = rand_word();
		pending_items = {pending_items, it};
	endtask

	task automatic settle_and_write(int idx, int val);
		while (pending_items.size() > 0 || req_valid || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx[0];
		cfg_wdata <= val[9:0];
		if (idx == 0) seg_ticks = val & 8'hFF;
		else period_ms = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one taught trajectory: clear, appends, start, ticks through done, with rare stray clear/append/start items
	task automatic queue_replay(int nw, int nticks);
		queue_item(KIND_CLEAR);
		repeat (nw) queue_item(KIND_APPEND);
		queue_item(KIND_START);
		repeat (nticks) begin
			if ($urandom_range(0, 40) == 0) queue_item($urandom_range(0, 2));
			queue_item(KIND_TICK);
		end
	endtask

	int total;
	initial begin
		int nw, n;
		way_cnt = 0; tick_cnt = 0; replaying = 0;
		seg_ticks = 10; period_ms = 100;
		errors = 0; sent = 0; received = 0; ticks_cmd = 0; dones = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, too few, stray kinds, stop, busy, edge values
		queue_item(KIND_TICK);
		queue_item(KIND_START);
		queue_item(KIND_APPEND);
		queue_item(KIND_START);
		queue_item(3'd5); queue_item(3'd6); queue_item(3'd7);
		queue_item(KIND_APPEND);
		queue_item(KIND_START);
		queue_item(KIND_APPEND);
		queue_item(KIND_CLEAR);
		queue_item(KIND_START);
		repeat (5) queue_item(KIND_TICK);
		queue_item(KIND_STOP);
		queue_item(KIND_TICK);
		total = pending_items.size();

		// table full check, then settings sweep
		settle_and_write(0, 1);
		settle_and_write(1, 1000);
		queue_item(KIND_CLEAR);
		repeat (NWAY + 2) queue_item(KIND_APPEND);
		queue_item(KIND_START);
		repeat (8) queue_item(KIND_TICK);
		queue_item(KIND_STOP);
		total += pending_items.size();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin settle_and_write(0, 255); settle_and_write(1, 1); end
				1: begin settle_and_write(0, 0); settle_and_write(1, 0); end
				2: begin settle_and_write(0, 7); settle_and_write(1, 1023); end
				3: begin settle_and_write(0, 3); settle_and_write(1, 250); end
				default: begin
					settle_and_write(0, $urandom_range(1, 12));
					settle_and_write(1, $urandom_range(0, 1023));
				end
			endcase
			n = (seg_ticks == 0) ? 1 : seg_ticks;
			while (pending_items.size() < 80) begin
				nw = $urandom_range(1, 5);
				if (n > 20) nw = 2;
				queue_replay(nw, (nw > 1 ? (nw - 1) * n + 1 : 1) + $urandom_range(0, 2));
				if ($urandom_range(0, 3) == 0) queue_item($urandom_range(0, 7));
			end
			total += pending_items.size();
		end

		while (pending_items.size() > 0 || req_valid || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("items queued %0d, sent %0d, results %0d, position commands %0d, replays %0d",
			total, sent, received, ticks_cmd, dones);
		$display("covered clear/append/start/tick/stop, busy, full, too-few and odd kinds");
		if (errors == 0 && expected_rsp.size() == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#60ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
